// File: src/ptt_pkg.sv
`default_nettype none

package ptt_pkg;

   localparam int NumTimers  = 16;
   localparam int SlotW      = $clog2(NumTimers);
   localparam int MaxResults = 16;
   localparam int CntW       = $clog2(MaxResults + 1);

   typedef logic [SlotW-1:0] slot_idx_type;
   typedef logic [CntW-1:0]  cnt_type;
   typedef logic [3:0]       slot_out_type;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_ADD    = 2'd1,
      REQ_REMOVE = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_FIRE    = 2'd0,
      KIND_ADD_OK  = 2'd1,
      KIND_ADD_REJ = 2'd2
   } rsp_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [15:0] countdown;
      logic [15:0] period;
      logic [15:0] remaining;
      logic [15:0] code;
      logic [31:0] target;
   } timer_rec_type;

   localparam int RecW = $bits(timer_rec_type);

   typedef struct packed {
      rsp_kind_type kind;
      slot_out_type slot_out;
      logic [15:0]  code_out;
      logic [31:0]  target_out;
      logic         last;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type res;
   } push_type;

   typedef struct packed {
      logic pend_valid;
      logic pend_last;
      logic out_free;
   } out_stat_type;

endpackage

`default_nettype wire

// File: src/ptt_req_if.sv
`default_nettype none

interface ptt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [3:0]  slot;
   logic [15:0] event_code;
   logic [31:0] target_id;
   logic [15:0] period_ticks;
   logic [15:0] repeat_count;

   modport source (
      output valid, req_type, slot, event_code, target_id, period_ticks, repeat_count,
      input  ready
   );
   modport sink (
      input  valid, req_type, slot, event_code, target_id, period_ticks, repeat_count,
      output ready
   );
endinterface

`default_nettype wire

// File: src/ptt_rsp_if.sv
`default_nettype none

interface ptt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [3:0]  slot_out;
   logic [15:0] code_out;
   logic [31:0] target_out;
   logic        last;

   modport source (
      output valid, kind, slot_out, code_out, target_out, last,
      input  ready
   );
   modport sink (
      input  valid, kind, slot_out, code_out, target_out, last,
      output ready
   );
endinterface

`default_nettype wire

// File: src/periodic_timer_table.sv
// Periodic timer table with NUM_TIMERS slots (ptt_pkg::NumTimers, 16 here).
// req_ch carries one request word: tick, add timer or remove timer. rsp_ch
// returns result words: one per add (slot allocated, or rejected when the
// table is full or the period is zero), and one per timer that fires on a
// tick, in ascending slot order, with last set on the final word of the tick.
// Remove and a tick where nothing fires return no word.
// Timer records sit in one single-port-write, registered-read RAM; the slot
// valid bits are flip-flops. A tick walks the RAM one slot per cycle while
// the result path does not stall, read ahead by one slot, so the RAM walk
// sets the tick rate.
// Each fire word is held back until the next fire or the end of the walk so
// that last can be attached; a word passes through the held register and
// then the output register before it reaches rsp_ch.
// If rsp_ch stalls while a new fire is found, the walk holds on that slot
// and re-reads it until the output register frees. req_ch is taken only
// between walks and while the held word can move on.
// Reset clears all slots to free and empties the output; no RAM clear is
// needed since records are read only for valid slots.
`default_nettype none

module periodic_timer_table (
   input  wire logic clock,
   input  wire logic reset,
   ptt_req_if.sink   req_ch,
   ptt_rsp_if.source rsp_ch
);

   ptt_pkg::push_type            push;
   logic                         set_last;
   ptt_pkg::out_stat_type        stat;
   logic                         ram_we;
   ptt_pkg::slot_idx_type        ram_waddr;
   logic [ptt_pkg::RecW-1:0]     ram_wdata;
   ptt_pkg::slot_idx_type        ram_raddr;
   logic [ptt_pkg::RecW-1:0]     ram_rdata;

   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .push      (push),
      .set_last  (set_last),
      .stat      (stat),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   ptt_ram #(
      .WIDTH (ptt_pkg::RecW),
      .DEPTH (ptt_pkg::NumTimers)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ptt_out u_out (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .set_last (set_last),
      .stat     (stat),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

// File: src/ptt_ram.sv
`default_nettype none

module ptt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/ptt_ctrl.sv
`default_nettype none

module ptt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ptt_req_if.sink                    req_ch,
   output ptt_pkg::push_type          push,
   output logic                       set_last,
   input  wire ptt_pkg::out_stat_type stat,
   output logic                       ram_we,
   output ptt_pkg::slot_idx_type      ram_waddr,
   output logic [ptt_pkg::RecW-1:0]   ram_wdata,
   output ptt_pkg::slot_idx_type      ram_raddr,
   input  wire logic [ptt_pkg::RecW-1:0] ram_rdata
);

   ptt_pkg::state_type               state_ff, state_in;
   ptt_pkg::slot_idx_type            idx_ff, idx_in;
   ptt_pkg::cnt_type                 fire_cnt_ff, fire_cnt_in;
   logic [ptt_pkg::NumTimers-1:0]    valid_ff, valid_in;

   ptt_pkg::timer_rec_type rec, wrec;
   ptt_pkg::slot_idx_type  free_idx;
   logic                   free_found;
   logic                   pend_avail;
   logic                   accept;
   logic [15:0]            cd_dec, rem_dec;
   logic                   fire, report, stall, done;

   assign rec = ptt_pkg::timer_rec_type'(ram_rdata);

   // lowest free slot
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = ptt_pkg::NumTimers - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx   = ptt_pkg::slot_idx_type'(i);
            free_found = 1'b1;
         end
      end
   end

   assign pend_avail   = !stat.pend_valid || (stat.pend_last && stat.out_free);
   assign req_ch.ready = (state_ff == ptt_pkg::ST_IDLE) && pend_avail;
   assign accept       = req_ch.valid && req_ch.ready;

   assign cd_dec  = rec.countdown - 16'd1;
   assign rem_dec = rec.remaining - 16'd1;
   assign fire    = valid_ff[idx_ff] && (rec.remaining != 16'd0) && (cd_dec == 16'd0);
   assign report  = (state_ff == ptt_pkg::ST_SCAN) && fire
                    && (fire_cnt_ff < ptt_pkg::cnt_type'(ptt_pkg::MaxResults));
   assign stall   = report && stat.pend_valid && !stat.out_free;
   assign done    = (idx_ff == ptt_pkg::slot_idx_type'(ptt_pkg::NumTimers - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ptt_pkg::ST_IDLE;
         valid_ff    <= '0;
         idx_ff      <= '0;
         fire_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         idx_ff      <= idx_in;
         fire_cnt_ff <= fire_cnt_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      idx_in      = idx_ff;
      fire_cnt_in = fire_cnt_ff;
      push        = '0;
      set_last    = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = idx_ff;
      wrec        = rec;
      ram_raddr   = '0;

      unique case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (accept) begin
               case (ptt_pkg::req_code_type'(req_ch.req_type))
                  ptt_pkg::REQ_TICK: begin
                     state_in    = ptt_pkg::ST_SCAN;
                     idx_in      = '0;
                     fire_cnt_in = '0;
                  end
                  ptt_pkg::REQ_ADD: begin
                     push.valid    = 1'b1;
                     push.res.last = 1'b1;
                     if (free_found && (req_ch.period_ticks != 16'd0)) begin
                        push.res.kind     = ptt_pkg::KIND_ADD_OK;
                        push.res.slot_out = ptt_pkg::slot_out_type'(free_idx);
                        valid_in[free_idx] = 1'b1;
                        ram_we           = 1'b1;
                        ram_waddr        = free_idx;
                        wrec.countdown   = req_ch.period_ticks;
                        wrec.period      = req_ch.period_ticks;
                        wrec.remaining   = req_ch.repeat_count;
                        wrec.code        = req_ch.event_code;
                        wrec.target      = req_ch.target_id;
                     end else begin
                        push.res.kind = ptt_pkg::KIND_ADD_REJ;
                     end
                  end
                  ptt_pkg::REQ_REMOVE: begin
                     if (int'(req_ch.slot) < ptt_pkg::NumTimers) begin
                        valid_in[ptt_pkg::slot_idx_type'(req_ch.slot)] = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ptt_pkg::ST_SCAN: begin
            // re-read the same slot while the result path is blocked
            ram_raddr = stall ? idx_ff : ptt_pkg::slot_idx_type'(idx_ff + 1'b1);
            if (!stall) begin
               if (valid_ff[idx_ff]) begin
                  if (rec.remaining == 16'd0) begin
                     valid_in[idx_ff] = 1'b0;
                  end else if (cd_dec != 16'd0) begin
                     ram_we         = 1'b1;
                     wrec.countdown = cd_dec;
                  end else begin
                     ram_we         = 1'b1;
                     wrec.countdown = rec.period;
                     wrec.remaining = rem_dec;
                     if (rem_dec == 16'd0) begin
                        valid_in[idx_ff] = 1'b0;
                     end
                  end
               end
               if (report) begin
                  push.valid          = 1'b1;
                  push.res.kind       = ptt_pkg::KIND_FIRE;
                  push.res.slot_out   = ptt_pkg::slot_out_type'(idx_ff);
                  push.res.code_out   = rec.code;
                  push.res.target_out = rec.target;
                  push.res.last       = done;
                  fire_cnt_in         = ptt_pkg::cnt_type'(fire_cnt_ff + 1'b1);
               end
               if (done) begin
                  state_in = ptt_pkg::ST_IDLE;
                  set_last = !report;
               end else begin
                  idx_in = ptt_pkg::slot_idx_type'(idx_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = ptt_pkg::ST_IDLE;
         end
      endcase
   end

   assign ram_wdata = wrec;

   assert property (@(posedge clock) disable iff (reset)
      stall |-> (!ram_we && !push.valid))
      else $error("write or push issued during a result stall");

   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (!stat.pend_valid || stat.out_free))
      else $error("pushed result would overwrite a held word");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptt_pkg::ST_SCAN && state_in == ptt_pkg::ST_IDLE) |-> done)
      else $error("scan ended before the last slot");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptt_pkg::ST_SCAN && stall) |=> (idx_ff == $past(idx_ff)))
      else $error("scan index moved during a stall");

endmodule

`default_nettype wire

// File: src/ptt_out.sv
`default_nettype none

module ptt_out (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ptt_pkg::push_type  push,
   input  wire logic               set_last,
   output ptt_pkg::out_stat_type   stat,
   ptt_rsp_if.source               rsp_ch
);

   ptt_pkg::result_type pend_ff, pend_in;
   logic                pend_valid_ff, pend_valid_in;
   ptt_pkg::result_type out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_free;
   logic                move;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   // a held fire leaves only once the next one arrives or it is marked last
   assign move     = pend_valid_ff && out_free && (pend_ff.last || push.valid);

   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      if (move) begin
         out_in       = pend_ff;
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (push.valid) begin
         pend_in       = push.res;
         pend_valid_in = 1'b1;
      end else if (move) begin
         pend_valid_in = 1'b0;
      end
      if (set_last) begin
         pend_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign stat.pend_valid = pend_valid_ff;
   assign stat.pend_last  = pend_ff.last;
   assign stat.out_free   = out_free;

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.kind       = out_ff.kind;
   assign rsp_ch.slot_out   = out_ff.slot_out;
   assign rsp_ch.code_out   = out_ff.code_out;
   assign rsp_ch.target_out = out_ff.target_out;
   assign rsp_ch.last       = out_ff.last;

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ch.ready) |=> ($stable(out_ff) && out_valid_ff))
      else $error("stalled output word changed");

   assert property (@(posedge clock) disable iff (reset)
      (push.valid && pend_valid_ff) |-> move)
      else $error("held word dropped by a new push");

   assert property (@(posedge clock) disable iff (reset)
      set_last |-> !push.valid)
      else $error("last marker raised together with a push");

endmodule

`default_nettype wire
